// ===== rtl/flba_pkg.sv =====
`timescale 1ns / 1ps
// flba_pkg: shared types, constants and helpers of the free-list block allocator
// depends on nothing; every other rtl file refers to it by scoped names

package flba_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = 8;
	localparam int CNT_W      = 9;
	localparam int ADDR_W     = 2;
	localparam int DATA_W     = 32;

	localparam logic [ADDR_W-1:0] REG_BLOCK_COUNT = ADDR_W'(0);

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_ILLEGAL = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] block_index;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		status_t          status;
		logic [CNT_W-1:0] blocks_free;
	} out_item_t;

	// one stored entry: occupancy flag and link to the next free block
	typedef struct packed {
		logic             in_use;
		logic [IDX_W-1:0] link;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             clear;
	} mem_req_t;

	typedef struct packed {
		logic             rebuild;
		logic [CNT_W-1:0] new_count;
	} cfg_evt_t;

	// zero acts as one, anything above the pool size acts as the pool size
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] c;
		c = raw;
		if (c == '0) begin
			c = CNT_W'(1);
		end
		if (c > CNT_W'(MAX_BLOCKS)) begin
			c = CNT_W'(MAX_BLOCKS);
		end
		return c;
	endfunction

endpackage

// ===== rtl/flba_cfg.sv =====
`timescale 1ns / 1ps
// flba_cfg: register port holding block_count and raising the rebuild event
// depends on flba_pkg

module flba_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [flba_pkg::ADDR_W-1:0]        paddr,
	input  logic [flba_pkg::DATA_W-1:0]        pwdata,
	output logic [flba_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	output logic [flba_pkg::CNT_W-1:0]         eff_count,
	output flba_pkg::cfg_evt_t                 evt
);

	logic [flba_pkg::CNT_W-1:0] block_count_q;
	logic                       wr_fire;

	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && (paddr == flba_pkg::REG_BLOCK_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= flba_pkg::CNT_W'(flba_pkg::MAX_BLOCKS);
		end else if (wr_fire) begin
			block_count_q <= pwdata[flba_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == flba_pkg::REG_BLOCK_COUNT) begin
			prdata = flba_pkg::DATA_W'(block_count_q);
		end
	end

	assign eff_count     = flba_pkg::clamp_count(block_count_q);
	assign evt.rebuild   = wr_fire;
	assign evt.new_count = flba_pkg::clamp_count(pwdata[flba_pkg::CNT_W-1:0]);

endmodule

// ===== rtl/flba_mem.sv =====
`timescale 1ns / 1ps
// flba_mem: entry memory (link and occupancy) with registered read
// per-entry valid flops give the rebuilt list without a clearing sweep; depends on flba_pkg

module flba_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  flba_pkg::mem_req_t  req,
	output flba_pkg::entry_t    rd_entry
);

	flba_pkg::entry_t                 mem_q [flba_pkg::MAX_BLOCKS];
	logic [flba_pkg::MAX_BLOCKS-1:0]  valid_q;
	flba_pkg::entry_t                 rd_data_q;
	logic                             rd_valid_q;
	logic [flba_pkg::IDX_W-1:0]       rd_addr_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
			rd_addr_q <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	// an entry untouched since the last rebuild is free and links to its successor
	always_comb begin
		if (rd_valid_q) begin
			rd_entry = rd_data_q;
		end else begin
			rd_entry.in_use = 1'b0;
			rd_entry.link   = rd_addr_q + flba_pkg::IDX_W'(1);
		end
	end

	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en && req.wr_en |-> req.rd_addr != req.wr_addr)
		else $error("read and write hit the same entry in one cycle");

	a_no_clear_with_access: assert property (@(posedge clk) disable iff (!arst_n)
		req.clear |-> !req.wr_en && !req.rd_en)
		else $error("rebuild overlaps a memory access");

endmodule

// ===== rtl/flba_ctrl.sv =====
`timescale 1ns / 1ps
// flba_ctrl: request sequencer, list head, free counter and result register
// issues read-modify-write to flba_mem; depends on flba_pkg

module flba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  flba_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output flba_pkg::out_item_t         out_data,
	input  logic [flba_pkg::CNT_W-1:0]  eff_count,
	input  flba_pkg::cfg_evt_t          evt,
	output flba_pkg::mem_req_t          mem_req,
	input  flba_pkg::entry_t            rd_entry
);

	flba_pkg::state_t            state_q, state_d;
	flba_pkg::in_item_t          req_q;
	logic [flba_pkg::IDX_W-1:0]  head_q, head_d;
	logic [flba_pkg::CNT_W-1:0]  free_q, free_d;
	flba_pkg::out_item_t         out_q, out_d;
	logic                        out_valid_q, out_valid_d;
	logic                        in_fire;
	logic                        slot_free;
	logic                        illegal_free;

	assign in_stall  = (state_q != flba_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign illegal_free = ({1'b0, req_q.block_index} >= eff_count) || !rd_entry.in_use
		|| (free_q >= eff_count);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		free_d      = free_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && out_stall;

		mem_req.rd_en   = in_fire;
		mem_req.rd_addr = (in_data.req_type == flba_pkg::REQ_FREE) ? in_data.block_index
			: head_q;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = head_q;
		mem_req.wr_data = rd_entry;
		mem_req.clear   = evt.rebuild;

		case (state_q)
			flba_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = flba_pkg::ST_EXEC;
				end
			end
			flba_pkg::ST_EXEC: begin
				if (slot_free) begin
					state_d                 = flba_pkg::ST_IDLE;
					out_valid_d             = 1'b1;
					out_d.granted_index     = '0;
					out_d.status            = flba_pkg::STATUS_OK;
					if (req_q.req_type == flba_pkg::REQ_ALLOC) begin
						if (free_q == '0) begin
							out_d.status = flba_pkg::STATUS_EMPTY;
						end else begin
							// pop: mark head taken, follow its link
							out_d.granted_index    = head_q;
							mem_req.wr_en          = 1'b1;
							mem_req.wr_addr        = head_q;
							mem_req.wr_data.in_use = 1'b1;
							mem_req.wr_data.link   = rd_entry.link;
							head_d                 = rd_entry.link;
							free_d                 = free_q - flba_pkg::CNT_W'(1);
						end
					end else begin
						if (illegal_free) begin
							out_d.status = flba_pkg::STATUS_ILLEGAL;
						end else begin
							// push: freed block becomes the new head
							mem_req.wr_en          = 1'b1;
							mem_req.wr_addr        = req_q.block_index;
							mem_req.wr_data.in_use = 1'b0;
							mem_req.wr_data.link   = head_q;
							head_d                 = req_q.block_index;
							free_d                 = free_q + flba_pkg::CNT_W'(1);
						end
					end
					out_d.blocks_free = free_d;
				end
			end
			default: begin
				state_d = flba_pkg::ST_IDLE;
			end
		endcase

		if (evt.rebuild) begin
			head_d = '0;
			free_d = evt.new_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= flba_pkg::ST_IDLE;
			head_q      <= '0;
			free_q      <= flba_pkg::CNT_W'(flba_pkg::MAX_BLOCKS);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			free_q      <= free_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_data;
		end
		out_q <= out_d;
	end

	a_free_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= eff_count)
		else $error("free counter exceeds the block count");

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == flba_pkg::ST_EXEC && !in_stall == 1'b0)
		else $error("accepted request did not enter execution");

	a_grant_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != flba_pkg::STATUS_OK |-> out_q.granted_index == '0)
		else $error("failed request carries a granted index");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && !$past(evt.rebuild) && out_q.status == flba_pkg::STATUS_OK
		|-> out_q.blocks_free != $past(free_q))
		else $error("successful request left the free count unchanged");

endmodule

// ===== rtl/free_list_block_allocator_top.sv =====
`timescale 1ns / 1ps
// free_list_block_allocator_top: pool allocator handing out block indexes from a free list
// depends on flba_pkg, flba_cfg, flba_mem, flba_ctrl
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------------
//  in       | in        | in_valid / in_stall           | req_type, block_index
//  out      | out       | out_valid / out_stall         | granted_index, status, blocks_free
//  cfg      | in        | psel, penable, pwrite, pready | block_count at byte address 0
//
// each request runs in two steps: the IDLE state reads the head or freed entry from
// the entry memory, the EXEC state checks it, writes it back and loads the result register
// the next request is taken once the result register has room for the current one
// reset (and any block_count write) empties the memory valid flops at once: no sweep
// a stalled result holds the request in execution; the input sees in_stall meanwhile

module free_list_block_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  flba_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output flba_pkg::out_item_t          out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [flba_pkg::ADDR_W-1:0]  paddr,
	input  logic [flba_pkg::DATA_W-1:0]  pwdata,
	output logic [flba_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	logic [flba_pkg::CNT_W-1:0] eff_count;
	flba_pkg::cfg_evt_t         evt;
	flba_pkg::mem_req_t         mem_req;
	flba_pkg::entry_t           rd_entry;

	flba_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.eff_count (eff_count),
		.evt       (evt)
	);

	flba_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_entry (rd_entry)
	);

	flba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.eff_count (eff_count),
		.evt       (evt),
		.mem_req   (mem_req),
		.rd_entry  (rd_entry)
	);

endmodule
